// ===== rtl/core/rpc_pkg.sv =====
// ============================================================================
// Reflow profile controller package
// Shared stage codes, register indexes, widths and control constants.
// ============================================================================
package rpc_pkg;

    // Field widths
    localparam int TEMP_W  = 11;
    localparam int SP_W    = 9;
    localparam int SEC_W   = 16;
    localparam int GAIN_W  = 8;
    localparam int DRIVE_W = 8;
    localparam int STAGE_W = 3;
    localparam int ERR_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Width of the setpoint minus temperature difference
    localparam int DIFF_W = 13;
    // Width of the signed PD sum
    localparam int PD_W = 15;

    // Profile stages
    localparam logic [STAGE_W-1:0] STAGE_IDLE    = 3'd0;
    localparam logic [STAGE_W-1:0] STAGE_PREHEAT = 3'd1;
    localparam logic [STAGE_W-1:0] STAGE_REFLOW  = 3'd2;
    localparam logic [STAGE_W-1:0] STAGE_SOAK    = 3'd3;
    localparam logic [STAGE_W-1:0] STAGE_COOL    = 3'd4;

    // Profile selections
    localparam logic [1:0] MODE_REFLOW = 2'd1;
    localparam logic [1:0] MODE_SOAK   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PREHEAT_SP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREHEAT_SEC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFLOW_SP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REFLOW_SEC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOAK_SP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX   = 3'd7;

    // Control bands and limits
    localparam logic signed [DIFF_W-1:0] FULL_BAND = 13'sd10;
    localparam logic signed [DIFF_W-1:0] HOLD_BAND = 13'sd5;
    localparam logic [DRIVE_W-1:0] DRIVE_OFF = 8'd255;
    localparam logic [DRIVE_W-1:0] DRIVE_FULL = 8'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_MIN = 8'd0;
    localparam logic [SEC_W-1:0] SEC_MAX = 16'hFFFF;

    // Register reset values
    localparam logic [SP_W-1:0]    RST_PREHEAT_SP  = 9'd150;
    localparam logic [SEC_W-1:0]   RST_PREHEAT_SEC = 16'd30;
    localparam logic [SP_W-1:0]    RST_REFLOW_SP   = 9'd210;
    localparam logic [SEC_W-1:0]   RST_REFLOW_SEC  = 16'd20;
    localparam logic [SP_W-1:0]    RST_SOAK_SP     = 9'd200;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P      = 8'd25;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D      = 8'd100;
    localparam logic [DRIVE_W-1:0] RST_DRIVE_MAX   = 8'd255;

    // One result beat
    typedef struct packed {
        logic [SEC_W-1:0]   hold_count;
        logic               holding;
        logic [STAGE_W-1:0] stage;
        logic [DRIVE_W-1:0] ssr_drive;
    } result_t;

endpackage

// ===== rtl/core/reflow_profile_controller_top.sv =====
// ============================================================================
// Reflow profile controller
// Steps a reflow oven profile and computes an inverted PD heater drive.
// ============================================================================
// Usage:
// Each beat on the s_axis channel is one control period: tdata carries the
// measured temperature, a one-second tick, stop and start presses and the
// profile mode. Each accepted beat gives exactly one beat on m_axis with the
// heater drive (0 full on, 255 off), the stage after the period, the hold
// flag and the hold seconds.
// A beat that is accepted is offered on m_axis from the next cycle.
// Throughput is one beat per cycle while results are taken; the single
// result register is refilled in the same cycle that its beat is taken, so
// s_axis_tready follows m_axis_tready whenever a result is waiting.
// When the receiver stalls, the result holds and one more input beat is not
// taken until it drains; the profile state only advances on accepted beats.
// Configuration writes on the cfg channel are always ready and take effect
// at the next edge; they are meant to be made while no beat is in flight.
// Reset brings the block to idle with no result offered, clears the hold
// state and previous error, and loads the default profile registers.
// ============================================================================
module reflow_profile_controller_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Fields from bit 0: temperature[10:0], second_tick[11], stop_press[12],
    // start_press[13], mode[15:14]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rpc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // Fields from bit 0: ssr_drive[7:0], stage[10:8], holding[11],
    // hold_count[27:12], zero fill [31:28]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rpc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Configuration registers
    logic [rpc_pkg::SP_W-1:0]    preheat_sp_reg;
    logic [rpc_pkg::SEC_W-1:0]   preheat_sec_reg;
    logic [rpc_pkg::SP_W-1:0]    reflow_sp_reg;
    logic [rpc_pkg::SEC_W-1:0]   reflow_sec_reg;
    logic [rpc_pkg::SP_W-1:0]    soak_sp_reg;
    logic [rpc_pkg::GAIN_W-1:0]  gain_p_reg;
    logic [rpc_pkg::GAIN_W-1:0]  gain_d_reg;
    logic [rpc_pkg::DRIVE_W-1:0] drive_max_reg;

    // Profile state
    logic [rpc_pkg::STAGE_W-1:0] stage_reg, stage_next;
    logic                        hold_reg, hold_next;
    logic [rpc_pkg::SEC_W-1:0]   count_reg, count_next;
    logic [rpc_pkg::ERR_W-1:0]   prev_err_reg, prev_err_next;

    // Result register
    logic                        out_valid_reg;
    rpc_pkg::result_t            result_reg, result_next;

    // Handshake
    logic in_fire;
    logic cfg_fire;

    // Unpacked input fields
    logic signed [rpc_pkg::TEMP_W-1:0] temperature;
    logic                              second_tick;
    logic                              stop_press;
    logic                              start_press;
    logic [1:0]                        mode;

    // Stage parameters and PD datapath
    logic                              heating;
    logic [rpc_pkg::SP_W-1:0]          setpoint;
    logic [rpc_pkg::SEC_W-1:0]         duration;
    logic [rpc_pkg::STAGE_W-1:0]       next_stage;
    logic signed [rpc_pkg::DIFF_W-1:0] diff;
    logic [rpc_pkg::ERR_W-1:0]         err;
    logic signed [rpc_pkg::ERR_W+1:0]  err_delta;
    logic signed [rpc_pkg::PD_W-1:0]   p_term;
    logic signed [rpc_pkg::PD_W-1:0]   d_term;
    logic signed [rpc_pkg::PD_W-1:0]   pd_sum;
    logic [rpc_pkg::DRIVE_W-1:0]       pd_clamped;
    logic [rpc_pkg::DRIVE_W-1:0]       drive;
    logic                              in_band;
    logic [rpc_pkg::SEC_W-1:0]         count_ticked;
    logic                              advance;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;

    assign temperature = $signed(s_axis_tdata[10:0]);
    assign second_tick = s_axis_tdata[11];
    assign stop_press  = s_axis_tdata[12];
    assign start_press = s_axis_tdata[13];
    assign mode        = s_axis_tdata[15:14];

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preheat_sp_reg  <= rpc_pkg::RST_PREHEAT_SP;
            preheat_sec_reg <= rpc_pkg::RST_PREHEAT_SEC;
            reflow_sp_reg   <= rpc_pkg::RST_REFLOW_SP;
            reflow_sec_reg  <= rpc_pkg::RST_REFLOW_SEC;
            soak_sp_reg     <= rpc_pkg::RST_SOAK_SP;
            gain_p_reg      <= rpc_pkg::RST_GAIN_P;
            gain_d_reg      <= rpc_pkg::RST_GAIN_D;
            drive_max_reg   <= rpc_pkg::RST_DRIVE_MAX;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                rpc_pkg::REG_PREHEAT_SP:  preheat_sp_reg  <= cfg_data[rpc_pkg::SP_W-1:0];
                rpc_pkg::REG_PREHEAT_SEC: preheat_sec_reg <= cfg_data;
                rpc_pkg::REG_REFLOW_SP:   reflow_sp_reg   <= cfg_data[rpc_pkg::SP_W-1:0];
                rpc_pkg::REG_REFLOW_SEC:  reflow_sec_reg  <= cfg_data;
                rpc_pkg::REG_SOAK_SP:     soak_sp_reg     <= cfg_data[rpc_pkg::SP_W-1:0];
                rpc_pkg::REG_GAIN_P:      gain_p_reg      <= cfg_data[rpc_pkg::GAIN_W-1:0];
                rpc_pkg::REG_GAIN_D:      gain_d_reg      <= cfg_data[rpc_pkg::GAIN_W-1:0];
                rpc_pkg::REG_DRIVE_MAX:   drive_max_reg   <= cfg_data[rpc_pkg::DRIVE_W-1:0];
                default:                  preheat_sp_reg  <= preheat_sp_reg;
            endcase
        end
    end

    // Setpoint, duration and successor of the current heating stage.
    always_comb
    begin
        heating    = 1'b1;
        setpoint   = rpc_pkg::RST_PREHEAT_SP;
        duration   = '0;
        next_stage = rpc_pkg::STAGE_IDLE;
        unique case (stage_reg)
            rpc_pkg::STAGE_PREHEAT:
            begin
                setpoint   = preheat_sp_reg;
                duration   = preheat_sec_reg;
                next_stage = rpc_pkg::STAGE_REFLOW;
            end
            rpc_pkg::STAGE_REFLOW:
            begin
                setpoint   = reflow_sp_reg;
                duration   = reflow_sec_reg;
                next_stage = rpc_pkg::STAGE_COOL;
            end
            rpc_pkg::STAGE_SOAK:
            begin
                setpoint   = soak_sp_reg;
                next_stage = rpc_pkg::STAGE_COOL;
            end
            default:
            begin
                heating = 1'b0;
            end
        endcase
    end

    // PD drive: off outside heating, full below the band, off above the setpoint, else inverted clamped PD.
    always_comb
    begin
        diff      = $signed({4'b0, setpoint}) - rpc_pkg::DIFF_W'(temperature);
        err       = diff[rpc_pkg::ERR_W-1:0];
        in_band   = (diff >= 0) && (diff <= rpc_pkg::FULL_BAND);
        err_delta = $signed({2'b0, err}) - $signed({2'b0, prev_err_reg});
        p_term    = rpc_pkg::PD_W'($signed({1'b0, gain_p_reg}))
                  * rpc_pkg::PD_W'($signed({1'b0, err}));
        d_term    = rpc_pkg::PD_W'($signed({1'b0, gain_d_reg}))
                  * rpc_pkg::PD_W'(err_delta);
        pd_sum    = p_term + d_term;
        if (pd_sum > $signed({7'b0, drive_max_reg}))
            pd_clamped = drive_max_reg;
        else if (pd_sum < $signed({7'b0, rpc_pkg::DRIVE_MIN}))
            pd_clamped = rpc_pkg::DRIVE_MIN;
        else
            pd_clamped = pd_sum[rpc_pkg::DRIVE_W-1:0];

        if (!heating)
            drive = rpc_pkg::DRIVE_OFF;
        else if (diff > rpc_pkg::FULL_BAND)
            drive = rpc_pkg::DRIVE_FULL;
        else if (diff < 0)
            drive = rpc_pkg::DRIVE_OFF;
        else
            drive = rpc_pkg::DRIVE_OFF - pd_clamped;

        prev_err_next = (heating && in_band) ? err : prev_err_reg;
    end

    // Profile sequencing and hold counting.
    always_comb
    begin
        count_ticked = count_reg;
        if (second_tick && (count_reg != rpc_pkg::SEC_MAX))
            count_ticked = count_reg + rpc_pkg::SEC_W'(1);

        advance    = stop_press;
        stage_next = stage_reg;
        hold_next  = hold_reg;
        count_next = count_reg;

        if (heating)
        begin
            if (hold_reg)
            begin
                count_next = count_ticked;
                if ((duration != '0) && (count_ticked > duration))
                    advance = 1'b1;
            end
            else if (diff < rpc_pkg::HOLD_BAND)
            begin
                hold_next  = 1'b1;
                count_next = '0;
            end
            if (advance)
            begin
                stage_next = next_stage;
                hold_next  = 1'b0;
                count_next = '0;
            end
        end
        else if (stage_reg == rpc_pkg::STAGE_COOL)
        begin
            if (stop_press)
                stage_next = rpc_pkg::STAGE_IDLE;
            hold_next  = 1'b0;
            count_next = '0;
        end
        else
        begin
            stage_next = rpc_pkg::STAGE_IDLE;
            hold_next  = 1'b0;
            count_next = '0;
            if (start_press && (mode == rpc_pkg::MODE_REFLOW))
                stage_next = rpc_pkg::STAGE_PREHEAT;
            else if (start_press && (mode == rpc_pkg::MODE_SOAK))
                stage_next = rpc_pkg::STAGE_SOAK;
        end

        result_next.ssr_drive  = drive;
        result_next.stage      = stage_next;
        result_next.holding    = hold_next;
        result_next.hold_count = hold_next ? count_next : '0;
    end

    // Profile state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= rpc_pkg::STAGE_IDLE;
            hold_reg      <= 1'b0;
            count_reg     <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                stage_reg    <= stage_next;
                hold_reg     <= hold_next;
                count_reg    <= count_next;
                prev_err_reg <= prev_err_next;
            end
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, result_reg};

    // Idle and cooling never hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((stage_reg == rpc_pkg::STAGE_IDLE) || (stage_reg == rpc_pkg::STAGE_COOL))
        |-> (!hold_reg && (count_reg == '0)))
    else $error("hold state set outside a heating stage");

    // A beat taken in idle or cooling leaves the heater off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ((stage_reg == rpc_pkg::STAGE_IDLE) ||
                     (stage_reg == rpc_pkg::STAGE_COOL)))
        |=> (m_axis_tdata[7:0] == rpc_pkg::DRIVE_OFF))
    else $error("heater driven while idle or cooling");

    // Every accepted beat is offered as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

    // State only moves on accepted beats.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> ($stable(stage_reg) && $stable(count_reg) && $stable(prev_err_reg)))
    else $error("profile state changed without an input beat");

endmodule

// ===== tb/reflow_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Reflow profile controller scoreboard
// Predicts the result beat of every accepted control period from an
// independent model of the profile sequencer and PD drive, then checks the
// result beats against those predictions in order.
// ============================================================================
package reflow_scoreboard_pkg;

    import rpc_pkg::*;

    // Mismatch lines beyond this count are counted but not printed.
    localparam int PRINT_LIMIT = 50;

    class reflow_scoreboard;

        // Profile registers as the block should hold them
        logic [SP_W-1:0]    preheat_sp;
        logic [SEC_W-1:0]   preheat_sec;
        logic [SP_W-1:0]    reflow_sp;
        logic [SEC_W-1:0]   reflow_sec;
        logic [SP_W-1:0]    soak_sp;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_d;
        logic [DRIVE_W-1:0] drive_max;

        // Profile state after the last accepted period
        logic [STAGE_W-1:0] stage_q;
        logic               hold_q;
        logic [SEC_W-1:0]   seconds_q;
        logic [ERR_W-1:0]   last_error;

        result_t     expected_q[$];
        int unsigned mismatches;

        function new();
            preheat_sp  = RST_PREHEAT_SP;
            preheat_sec = RST_PREHEAT_SEC;
            reflow_sp   = RST_REFLOW_SP;
            reflow_sec  = RST_REFLOW_SEC;
            soak_sp     = RST_SOAK_SP;
            gain_p      = RST_GAIN_P;
            gain_d      = RST_GAIN_D;
            drive_max   = RST_DRIVE_MAX;
            stage_q     = STAGE_IDLE;
            hold_q      = 1'b0;
            seconds_q   = '0;
            last_error  = '0;
            mismatches  = 0;
        endfunction

        // Mirror one register write accepted on the cfg channel.
        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PREHEAT_SP:  preheat_sp  = data[SP_W-1:0];
                REG_PREHEAT_SEC: preheat_sec = data[SEC_W-1:0];
                REG_REFLOW_SP:   reflow_sp   = data[SP_W-1:0];
                REG_REFLOW_SEC:  reflow_sec  = data[SEC_W-1:0];
                REG_SOAK_SP:     soak_sp     = data[SP_W-1:0];
                REG_GAIN_P:      gain_p      = data[GAIN_W-1:0];
                REG_GAIN_D:      gain_d      = data[GAIN_W-1:0];
                REG_DRIVE_MAX:   drive_max   = data[DRIVE_W-1:0];
                default: ;
            endcase
        endfunction

        // Inverted heater duty for one heating period; updates the stored
        // error only inside the PD band.
        function logic [DRIVE_W-1:0] heater_drive(int sp, int temp);
            int err;
            int duty;
            int kp;
            int kd;
            int ceiling;
            int floor_val;
            int off_val;
            kp        = gain_p;
            kd        = gain_d;
            ceiling   = drive_max;
            floor_val = DRIVE_MIN;
            off_val   = DRIVE_OFF;
            if (temp < sp - FULL_BAND)
                return DRIVE_FULL;
            if (temp > sp)
                return DRIVE_OFF;
            err  = sp - temp;
            duty = kp * err + kd * (err - int'(last_error));
            if (duty > ceiling)
                duty = ceiling;
            else if (duty < floor_val)
                duty = floor_val;
            last_error = ERR_W'(err);
            return DRIVE_W'(off_val - duty);
        endfunction

        // Step the profile for one accepted input beat and queue its result.
        function void note_input(logic [IN_DATA_W-1:0] beat);
            int                 temp;
            int                 sp;
            logic               tick;
            logic               stop;
            logic               start;
            logic [1:0]         mode;
            logic               advance;
            logic [SEC_W-1:0]   dur;
            logic [STAGE_W-1:0] next_stage;
            result_t            r;
            temp  = $signed(beat[TEMP_W-1:0]);
            tick  = beat[TEMP_W];
            stop  = beat[TEMP_W+1];
            start = beat[TEMP_W+2];
            mode  = beat[TEMP_W+4:TEMP_W+3];
            r.ssr_drive = DRIVE_OFF;
            case (stage_q)
                STAGE_PREHEAT, STAGE_REFLOW, STAGE_SOAK:
                begin
                    if (stage_q == STAGE_PREHEAT)
                    begin
                        sp = preheat_sp;
                        dur = preheat_sec;
                        next_stage = STAGE_REFLOW;
                    end
                    else if (stage_q == STAGE_REFLOW)
                    begin
                        sp = reflow_sp;
                        dur = reflow_sec;
                        next_stage = STAGE_COOL;
                    end
                    else
                    begin
                        // Soak holds until a stop press.
                        sp = soak_sp;
                        dur = '0;
                        next_stage = STAGE_COOL;
                    end
                    r.ssr_drive = heater_drive(sp, temp);
                    advance = stop;
                    if (hold_q)
                    begin
                        if (tick && seconds_q != SEC_MAX)
                            seconds_q = seconds_q + 1'b1;
                        if (dur != 0 && seconds_q > dur)
                            advance = 1'b1;
                    end
                    else if (temp > sp - HOLD_BAND)
                    begin
                        // The tick of the entry period is not counted.
                        hold_q = 1'b1;
                        seconds_q = '0;
                    end
                    if (advance)
                    begin
                        stage_q = next_stage;
                        hold_q = 1'b0;
                        seconds_q = '0;
                    end
                end
                STAGE_COOL:
                begin
                    if (stop)
                        stage_q = STAGE_IDLE;
                    hold_q = 1'b0;
                    seconds_q = '0;
                end
                default:
                begin
                    stage_q = STAGE_IDLE;
                    hold_q = 1'b0;
                    seconds_q = '0;
                    if (start)
                    begin
                        if (mode == MODE_REFLOW)
                            stage_q = STAGE_PREHEAT;
                        else if (mode == MODE_SOAK)
                            stage_q = STAGE_SOAK;
                    end
                end
            endcase
            r.stage = stage_q;
            r.holding = hold_q;
            r.hold_count = hold_q ? seconds_q : '0;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            if (mismatches < PRINT_LIMIT)
                $display("%0t mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one accepted result beat with the oldest prediction.
        task check_result(logic [OUT_DATA_W-1:0] beat);
            result_t got;
            result_t want;
            got = result_t'(beat[$bits(result_t)-1:0]);
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result beat %h with nothing expected", beat));
                return;
            end
            want = expected_q.pop_front();
            if (got.ssr_drive != want.ssr_drive)
                report_mismatch($sformatf("ssr_drive %0d, expected %0d",
                                          got.ssr_drive, want.ssr_drive));
            if (got.stage != want.stage)
                report_mismatch($sformatf("stage %0d, expected %0d", got.stage, want.stage));
            if (got.holding != want.holding)
                report_mismatch($sformatf("holding %0d, expected %0d",
                                          got.holding, want.holding));
            if (got.hold_count != want.hold_count)
                report_mismatch($sformatf("hold_count %0d, expected %0d",
                                          got.hold_count, want.hold_count));
        endtask

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Reflow profile controller testbench
// Drives control periods through the stream input with random gaps and
// back-pressure, checks every result beat against a predicted profile and
// PD drive, and sweeps the profile registers over several settings,
// including their extremes and a hold at the largest duration.
// ============================================================================
module testbench;

    import rpc_pkg::*;
    import reflow_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int unsigned run_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    reflow_scoreboard sb;

    reflow_profile_controller_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 12 ns clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
        run_cycles <= run_cycles + 1;

    initial
    begin
        wait (run_cycles >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: check each accepted beat and stall at random.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one control period; returns in the step of its acceptance with
    // tvalid still high.
    task automatic send_period(input int temp, input logic tick, input logic stop,
                               input logic start, input logic [1:0] mode);
        logic [IN_DATA_W-1:0] beat;
        beat = {mode, start, stop, tick, TEMP_W'(temp)};
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= beat;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        sb.note_input(beat);
    endtask

    // Stop sending and let every predicted result drain.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        sb.write_register(idx, CFG_DATA_W'(value));
    endtask

    // Load a whole profile while no beat is in flight.
    task automatic load_profile(input int pre_sp, input int pre_sec, input int ref_sp,
                                input int ref_sec, input int soak, input int kp,
                                input int kd, input int dmax);
        wait_for_results();
        write_reg(REG_PREHEAT_SP, pre_sp);
        write_reg(REG_PREHEAT_SEC, pre_sec);
        write_reg(REG_REFLOW_SP, ref_sp);
        write_reg(REG_REFLOW_SEC, ref_sec);
        write_reg(REG_SOAK_SP, soak);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_DRIVE_MAX, dmax);
        cfg_valid <= 1'b0;
    endtask

    // Random period shaped by the predicted stage: mostly a plausible run
    // through the profile, with some pure noise.
    task automatic random_period();
        int         temp;
        int         sp;
        int         offset;
        logic       tick;
        logic       stop;
        logic       start;
        logic [1:0] mode;
        tick = ($urandom_range(99) < 60);
        mode = 2'($urandom);
        if ($urandom_range(99) < 8)
        begin
            temp  = $urandom_range(1050);
            temp  = temp - 200;
            tick  = 1'($urandom);
            stop  = ($urandom_range(3) == 0);
            start = 1'($urandom);
        end
        else
        begin
            case (sb.stage_q)
                STAGE_PREHEAT, STAGE_REFLOW, STAGE_SOAK:
                begin
                    sp = (sb.stage_q == STAGE_PREHEAT) ? sb.preheat_sp :
                         (sb.stage_q == STAGE_REFLOW)  ? sb.reflow_sp : sb.soak_sp;
                    offset = $urandom_range(18);
                    temp  = sp + offset - 14;
                    stop  = ($urandom_range(99) < 4);
                    start = ($urandom_range(99) < 5);
                end
                STAGE_COOL:
                begin
                    temp  = $urandom_range(300);
                    stop  = ($urandom_range(99) < 25);
                    start = ($urandom_range(99) < 10);
                end
                default:
                begin
                    temp  = $urandom_range(60);
                    stop  = ($urandom_range(99) < 10);
                    start = ($urandom_range(99) < 70);
                    if ($urandom_range(99) < 80)
                        mode = $urandom_range(1) ? MODE_REFLOW : MODE_SOAK;
                end
            endcase
        end
        send_period(temp, tick, stop, start, mode);
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed periods with the reset profile.
        send_idle_pct = 14;
        recv_idle_pct = 69;
        send_period(-200, 1'b1, 1'b1, 1'b0, 2'd0);         // stop in idle is ignored
        send_period(850, 1'b0, 1'b0, 1'b1, 2'd0);          // start with mode 0
        send_period(0, 1'b1, 1'b0, 1'b1, 2'd3);            // start with mode 3
        send_period(25, 1'b0, 1'b0, 1'b1, MODE_REFLOW);    // enter preheat
        send_period(-200, 1'b1, 1'b0, 1'b1, MODE_SOAK);    // full drive, start ignored
        send_period(140, 1'b0, 1'b0, 1'b0, 2'd0);          // edge of the PD band
        send_period(145, 1'b1, 1'b0, 1'b0, 2'd0);          // negative PD, not yet holding
        send_period(146, 1'b1, 1'b0, 1'b0, 2'd0);          // hold entered, tick dropped
        send_period(150, 1'b1, 1'b0, 1'b0, 2'd0);          // first counted second
        send_period(151, 1'b0, 1'b0, 1'b0, 2'd0);          // above setpoint, heater off
        send_period(150, 1'b1, 1'b1, 1'b0, 2'd0);          // stop while holding
        send_period(850, 1'b1, 1'b0, 1'b0, 2'd0);          // reflow, hold at once
        send_period(205, 1'b1, 1'b0, 1'b0, 2'd0);
        send_period(100, 1'b0, 1'b1, 1'b1, MODE_REFLOW);   // stop into cooling
        send_period(300, 1'b1, 1'b0, 1'b1, MODE_SOAK);     // start ignored in cooling
        send_period(25, 1'b0, 1'b1, 1'b0, 2'd0);           // stop in cooling to idle
        send_period(25, 1'b0, 1'b0, 1'b1, MODE_SOAK);      // enter soak
        send_period(196, 1'b1, 1'b0, 1'b0, 2'd0);
        repeat (3) send_period(200, 1'b1, 1'b0, 1'b0, 2'd0);
        send_period(199, 1'b1, 1'b1, 1'b0, 2'd0);          // stop in soak
        send_period(-1, 1'b1, 1'b1, 1'b0, 2'd3);

        // Random periods over three idle patterns and three profiles each.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 14 : 0;
            for (int setting = 0; setting < 3; setting++)
            begin
                case (setting)
                    0: load_profile($urandom_range(500), $urandom_range(6),
                                    $urandom_range(500), $urandom_range(6),
                                    $urandom_range(500), $urandom_range(255),
                                    $urandom_range(255), $urandom_range(255));
                    1: load_profile(0, 0, 500, 1, 0, 255, 255, 0);
                    default: load_profile(500, 1, 0, 0, 500, 0, 0, 255);
                endcase
                for (int n = 0; n < 55; n++)
                begin
                    if (n == 27)
                        wait_for_results();
                    random_period();
                end
            end
        end

        // Preheat hold at the largest duration: it keeps counting until stop.
        load_profile(150, 65535, 210, 3, 200, 25, 100, 255);
        while (sb.stage_q != STAGE_IDLE)
            send_period(25, 1'b0, 1'b1, 1'b0, 2'd0);
        send_period(25, 1'b0, 1'b0, 1'b1, MODE_REFLOW);
        for (int n = 0; n < 20; n++)
            send_period(146 + $urandom_range(4), 1'b1, 1'b0, 1'b0, 2'd0);
        send_period(150, 1'b1, 1'b1, 1'b0, 2'd0);

        wait_for_results();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rpc_pkg.sv
rtl/core/reflow_profile_controller_top.sv
tb/reflow_scoreboard_pkg.sv
tb/testbench.sv
